@@ rtl/core/p1305_pkg.sv @@
// package for the poly1305 mac engine: payload structs, register map, key clamp masks
// no dependencies; used by poly1305_mac_engine
package p1305_pkg;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [4:0]  block_bytes;
        logic        final_block;
    } msg_t;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } tag_t;

    // register indexes, byte address is 8 * index
    localparam logic [1:0] REG_R_LOW  = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW  = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    localparam logic [63:0] CLAMP_LO = 64'h0fff_fffc_0fff_ffff;
    localparam logic [63:0] CLAMP_HI = 64'h0fff_fffc_0fff_fffc;

    localparam int LIMB_W  = 26;
    localparam int NUM_LIMBS = 5;
    localparam int MAX_BYTES = 16;

endpackage

@@ rtl/core/poly1305_mac_engine.sv @@
// poly1305 mac engine top level: apb key registers, block padding, iterative
// limb multiply-accumulate, reduction mod 2^130-5 and tag output; uses p1305_pkg
//
// operation: a block is accepted in idle, then the shared 27x29 multiply-accumulate
// unit runs the 5x5 limb products, then 3 reduce steps (fold1, fold2, final);
// a final block then enters the tag state; an empty final block goes there at accept
// flow: a new block is taken only in idle; the tag state waits on tag_ready
// reset: asynchronous active low; clears the key registers, the accumulator and control
module poly1305_mac_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              msg_valid,
    output logic              msg_ready,
    input  p1305_pkg::msg_t   msg,
    output logic              tag_valid,
    input  logic              tag_ready,
    output p1305_pkg::tag_t   tag
);
    import p1305_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_FOLD1 = 3'd2;
    localparam logic [2:0] ST_FOLD2 = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;
    localparam logic [2:0] ST_TAG   = 3'd5;

    localparam logic [2:0] LAST_LIMB = 3'(NUM_LIMBS - 1);

    logic [2:0]   state_reg, state_next;
    logic [63:0]  r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic [129:0] acc_reg, acc_next;
    logic [130:0] a_reg, a_next;
    logic [2:0]   i_reg, i_next;
    logic [2:0]   j_reg, j_next;
    logic [58:0]  d_reg, d_next;
    logic [25:0]  h_reg [NUM_LIMBS];
    logic         h_we;
    logic         fin_reg, fin_next;
    logic         tag_valid_reg, tag_valid_next;
    tag_t         tag_reg;
    logic         tag_we;

    logic         cfg_we;
    logic         msg_acc;
    logic [4:0]   n_c;
    logic [7:0]   pad_shift;
    logic [127:0] blk_c;
    logic [128:0] m_c;
    logic [127:0] rc;
    logic [26:0]  a_limb;
    logic         wrap;
    logic [3:0]   k_wide;
    logic [2:0]   k_c;
    logic [25:0]  r_limb;
    logic [28:0]  r_sel;
    logic [55:0]  prod;
    logic [58:0]  d_sum;
    logic [35:0]  c5;
    logic [130:0] g_c;
    logic [127:0] tag_sum;

    assign pready    = 1'b1;
    assign cfg_we    = psel & penable & pwrite;
    assign msg_ready = (state_reg == ST_IDLE);
    assign msg_acc   = msg_valid & msg_ready;
    assign tag_valid = tag_valid_reg;
    assign tag       = tag_reg;

    always_comb
    begin
        unique case (paddr[4:3])
            REG_R_LOW:  prdata = r_low_reg;
            REG_R_HIGH: prdata = r_high_reg;
            REG_S_LOW:  prdata = s_low_reg;
            REG_S_HIGH: prdata = s_high_reg;
        endcase
    end

    // pad the block: drop stray bytes, put 0x01 after the last valid byte
    always_comb
    begin
        n_c = (msg.block_bytes > 5'(MAX_BYTES)) ? 5'(MAX_BYTES) : msg.block_bytes;
        pad_shift = {n_c, 3'b000};
        blk_c = {msg.block_high, msg.block_low};
        m_c = 129'(1) << pad_shift;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            if (5'(k) < n_c)
            begin
                m_c[8*k +: 8] = blk_c[8*k +: 8];
            end
        end
    end

    assign rc = {r_high_reg & CLAMP_HI, r_low_reg & CLAMP_LO};

    // shared multiply-accumulate: d_j += a_i * r_(j-i), wrapped terms use 5*r
    always_comb
    begin
        unique case (i_reg)
            3'd0:    a_limb = {1'b0, a_reg[25:0]};
            3'd1:    a_limb = {1'b0, a_reg[51:26]};
            3'd2:    a_limb = {1'b0, a_reg[77:52]};
            3'd3:    a_limb = {1'b0, a_reg[103:78]};
            3'd4:    a_limb = a_reg[130:104];
            default: a_limb = '0;
        endcase
        wrap   = (i_reg > j_reg);
        k_wide = {1'b0, j_reg} + (wrap ? 4'd5 : 4'd0) - {1'b0, i_reg};
        k_c    = k_wide[2:0];
        unique case (k_c)
            3'd0:    r_limb = rc[25:0];
            3'd1:    r_limb = rc[51:26];
            3'd2:    r_limb = rc[77:52];
            3'd3:    r_limb = rc[103:78];
            3'd4:    r_limb = {2'b00, rc[127:104]};
            default: r_limb = '0;
        endcase
        r_sel = wrap ? ({1'b0, r_limb, 2'b00} + {3'b000, r_limb}) : {3'b000, r_limb};
        prod  = 56'(a_limb) * 56'(r_sel);
        d_sum = d_reg + {3'b000, prod};
    end

    assign c5      = {1'b0, d_reg[32:0], 2'b00} + {3'b000, d_reg[32:0]};
    assign g_c     = {1'b0, a_reg[129:0]} + 131'd5;
    assign tag_sum = acc_reg[127:0] + {s_high_reg, s_low_reg};

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        d_next         = d_reg;
        fin_next       = fin_reg;
        h_we           = 1'b0;
        tag_we         = 1'b0;
        tag_valid_next = tag_valid_reg & ~tag_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    fin_next = msg.final_block;
                    a_next   = {1'b0, acc_reg} + {2'b00, m_c};
                    i_next   = '0;
                    j_next   = '0;
                    d_next   = '0;
                    if (msg.final_block && (n_c == '0))
                    begin
                        state_next = ST_TAG;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                if (i_reg == LAST_LIMB)
                begin
                    // limb done: keep low 26 bits, carry seeds the next limb
                    h_we   = 1'b1;
                    d_next = {26'd0, d_sum[58:26]};
                    i_next = '0;
                    j_next = j_reg + 3'd1;
                    if (j_reg == LAST_LIMB)
                    begin
                        state_next = ST_FOLD1;
                    end
                end
                else
                begin
                    d_next = d_sum;
                    i_next = i_reg + 3'd1;
                end
            end
            ST_FOLD1:
            begin
                // carry out of bit 130 folds back as 5 * carry
                a_next = {1'b0, h_reg[4], h_reg[3], h_reg[2], h_reg[1], h_reg[0]}
                         + {95'd0, c5};
                state_next = ST_FOLD2;
            end
            ST_FOLD2:
            begin
                a_next     = {1'b0, a_reg[129:0]} + (a_reg[130] ? 131'd5 : 131'd0);
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                // subtract p once if the value is at or above it
                acc_next   = g_c[130] ? g_c[129:0] : a_reg[129:0];
                state_next = fin_reg ? ST_TAG : ST_IDLE;
            end
            ST_TAG:
            begin
                if (!tag_valid_reg || tag_ready)
                begin
                    tag_we         = 1'b1;
                    tag_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            fin_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            tag_valid_reg <= 1'b0;
            r_low_reg     <= '0;
            r_high_reg    <= '0;
            s_low_reg     <= '0;
            s_high_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            fin_reg       <= fin_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            tag_valid_reg <= tag_valid_next;
            if (cfg_we)
            begin
                unique case (paddr[4:3])
                    REG_R_LOW:  r_low_reg  <= pwdata;
                    REG_R_HIGH: r_high_reg <= pwdata;
                    REG_S_LOW:  s_low_reg  <= pwdata;
                    REG_S_HIGH: s_high_reg <= pwdata;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        d_reg <= d_next;
        if (h_we)
        begin
            h_reg[j_reg] <= d_sum[25:0];
        end
        if (tag_we)
        begin
            tag_reg.tag_low  <= tag_sum[63:0];
            tag_reg.tag_high <= tag_sum[127:64];
        end
    end

endmodule

@@ sim/poly1305_mac_engine_tb.sv @@
// self-checking testbench for poly1305_mac_engine: apb key loads, directed and random
// message streams, tag prediction with wide modular arithmetic mod 2^130-5
// depends on p1305_pkg and poly1305_mac_engine
module poly1305_mac_engine_tb;

    import p1305_pkg::*;

    localparam logic [129:0] P1305 = 130'h3_ffff_ffff_ffff_ffff_ffff_ffff_ffff_fffb;
    // the engine may still hold a block, leave margin before touching the keys
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 800;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        msg_valid = 1'b0;
    logic        msg_ready;
    msg_t        msg = '0;
    logic        tag_valid;
    logic        tag_ready = 1'b0;
    tag_t        tag;

    // predictor state
    logic [63:0]  key_r_low, key_r_high, key_s_low, key_s_high;
    logic [129:0] mac_acc;
    tag_t         expected_tags[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;

    rx_mode_e    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;

    poly1305_mac_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .tag_valid (tag_valid),
        .tag_ready (tag_ready),
        .tag       (tag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fold the bits above 2^130 back in as 5, then one conditional subtract
    function automatic logic [129:0] mod_p1305(input logic [259:0] x);
        logic [259:0] t;
        t = x;
        while (t[259:130] != '0)
            t = t[129:0] + t[259:130] * 260'd5;
        if (t[129:0] >= P1305)
            t = t - P1305;
        return t[129:0];
    endfunction

    task automatic predict_mac_block(input msg_t blk);
        logic [4:0]   n_eff;
        logic [128:0] padded;
        logic [259:0] sum_wide;
        logic [259:0] r_wide;
        logic [127:0] tag_sum;
        tag_t         t;
        n_eff = (blk.block_bytes > 5'd16) ? 5'd16 : blk.block_bytes;
        // an empty final request only releases the tag
        if (!(blk.final_block && n_eff == 5'd0))
        begin
            padded = ({1'b0, blk.block_high, blk.block_low} & ((129'd1 << (8 * n_eff)) - 129'd1))
                     | (129'd1 << (8 * n_eff));
            sum_wide = 260'(mac_acc) + 260'(padded);
            r_wide = 260'({key_r_high & CLAMP_HI, key_r_low & CLAMP_LO});
            mac_acc = mod_p1305(sum_wide * r_wide);
        end
        if (blk.final_block)
        begin
            tag_sum = mac_acc[127:0] + {key_s_high, key_s_low};
            t.tag_low = tag_sum[63:0];
            t.tag_high = tag_sum[127:64];
            expected_tags.push_back(t);
            mac_acc = '0;
        end
    endtask

    function automatic msg_t make_block(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [4:0] nbytes, input logic fin);
        msg_t m;
        m.block_low = lo;
        m.block_high = hi;
        m.block_bytes = nbytes;
        m.final_block = fin;
        return m;
    endfunction

    function automatic msg_t rand_block(input logic fin);
        logic [63:0] lo, hi;
        int unsigned pick;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0)
        begin
            lo = '1;
            hi = '1;
        end
        if (!fin)
            pick = ($urandom_range(0, 3) != 0) ? 16 : $urandom_range(0, 31);
        else
            pick = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 16) : $urandom_range(17, 31);
        return make_block(lo, hi, pick[4:0], fin);
    endfunction

    function automatic logic [63:0] pick_key_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // bursts of back-to-back requests separated by random gaps, unless gaps are off
    task automatic sender_pace();
        if (!gaps_on)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 35 : 4)) @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    task automatic send_block(input msg_t blk);
        msg <= blk;
        msg_valid <= 1'b1;
        @(posedge clk);
        while (!msg_ready)
            @(posedge clk);
        predict_mac_block(blk);
        items_sent++;
        sender_pace();
    endtask

    task automatic sender_idle();
        msg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        sender_idle();
        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves psel high so back-to-back writes never lower and raise it in one step
    task automatic write_key_reg(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_R_LOW:  key_r_low = value;
            REG_R_HIGH: key_r_high = value;
            REG_S_LOW:  key_s_low = value;
            REG_S_HIGH: key_s_high = value;
        endcase
    endtask

    task automatic load_keys(input logic [63:0] rl, input logic [63:0] rh,
                             input logic [63:0] sl, input logic [63:0] sh);
        write_key_reg(REG_R_LOW, rl);
        write_key_reg(REG_R_HIGH, rh);
        write_key_reg(REG_S_LOW, sl);
        write_key_reg(REG_S_HIGH, sh);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_directed_blocks();
        logic [63:0] ones, alt;
        ones = '1;
        alt = 64'haaaa_aaaa_aaaa_aaaa;
        load_keys(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                  64'h0f0f_0f0f_f0f0_f0f0, 64'h8000_0000_0000_0001);
        // empty final on a clear accumulator, stray bytes must not leak in
        send_block(make_block(ones, ones, 5'd0, 1'b1));
        send_block(make_block(ones, ones, 5'd16, 1'b1));
        // empty non-final absorbs the lone pad byte
        send_block(make_block('0, '0, 5'd16, 1'b0));
        send_block(make_block(ones, ones, 5'd0, 1'b0));
        send_block(make_block(ones, ones, 5'd0, 1'b1));
        // partial lengths around the 8-byte boundary with stray bytes set
        send_block(make_block(ones, ones, 5'd1, 1'b1));
        send_block(make_block(ones, ones, 5'd7, 1'b1));
        send_block(make_block(ones, ones, 5'd8, 1'b1));
        send_block(make_block(ones, ones, 5'd9, 1'b1));
        send_block(make_block(ones, ones, 5'd15, 1'b1));
        // oversized length counts as a full block
        send_block(make_block(ones, ones, 5'd17, 1'b1));
        send_block(make_block(ones, ones, 5'd31, 1'b1));
        send_block(make_block(alt, ~alt, 5'd16, 1'b0));
        send_block(make_block(~alt, alt, 5'd12, 1'b1));
        drain_and_settle();
    endtask

    task automatic test_key_extremes();
        logic [63:0] ones;
        ones = '1;
        for (int k = 0; k < 4; k++)
        begin
            drain_and_settle();
            load_keys(k[0] ? ones : '0, k[0] ? ones : '0, k[1] ? ones : '0, k[1] ? ones : '0);
            send_block(make_block(ones, ones, 5'd16, 1'b0));
            send_block(make_block(ones, ones, 5'd16, 1'b0));
            send_block(make_block(ones, ones, 5'd0, 1'b1));
        end
        drain_and_settle();
    endtask

    // no gaps at all, then the sender holds off until every tag is back
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        load_keys(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
        for (int i = 0; i < 40; i++)
            send_block(rand_block(($urandom_range(0, 2) == 0) || (i == 39)));
        drain_and_settle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_messages();
        int start_items, last_rekey, nblk;
        start_items = items_sent;
        last_rekey = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            if (items_sent - last_rekey >= 100)
            begin
                drain_and_settle();
                load_keys(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
                last_rekey = items_sent;
            end
            gaps_on = ($urandom_range(0, 4) != 0);
            nblk = $urandom_range(1, 6);
            for (int i = 0; i < nblk; i++)
                send_block(rand_block(i == nblk - 1));
        end
        gaps_on = 1'b1;
    endtask

    // receiver stall pattern, switches character when its random run length expires
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:   tag_ready <= 1'b1;
            RX_COIN:   tag_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: tag_ready <= ($urandom_range(0, 3) == 0);
            default:   tag_ready <= rx_left[2];
        endcase
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("tag mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk)
    begin
        tag_t want;
        if (rst_n && tag_valid && tag_ready)
        begin
            if (expected_tags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tag with none pending: %h %h", tag.tag_high, tag.tag_low);
            end
            else
            begin
                want = expected_tags.pop_front();
                if (tag.tag_low !== want.tag_low)
                    note_mismatch("tag_low", want.tag_low, tag.tag_low);
                if (tag.tag_high !== want.tag_high)
                    note_mismatch("tag_high", want.tag_high, tag.tag_high);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        key_r_low = '0;
        key_r_high = '0;
        key_s_low = '0;
        key_s_high = '0;
        mac_acc = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_blocks();
        test_key_extremes();
        test_back_to_back();
        test_random_messages();
        drain_and_settle();
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/p1305_pkg.sv
rtl/core/poly1305_mac_engine.sv
sim/poly1305_mac_engine_tb.sv
